### rtl/rrspa_pkg.sv
`timescale 1ns / 1ps

package rrspa_pkg;

  localparam int SLOT_COUNT     = 256;
  localparam int SLOT_MAX_BYTES = 256;
  localparam int SLOT_STRIDE    = 256;

  localparam int SCAN_W    = (SLOT_COUNT >= 64) ? 64 : (2 ** $clog2(SLOT_COUNT));
  localparam int WORDS     = (SLOT_COUNT + SCAN_W - 1) / SCAN_W;
  localparam int POOL_W    = WORDS * SCAN_W;
  localparam int OFF_W     = $clog2(SCAN_W);
  localparam int WORD_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W     = WORD_W + OFF_W;
  localparam int STEP_W    = $clog2(WORDS + 1);
  localparam int STRIDE_SH = $clog2(SLOT_STRIDE);
  localparam int CNT_W     = 64;
  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int GRANT_W   = 8;

  localparam logic [ADDR_W-1:0] POOL_SPAN = ADDR_W'(SLOT_COUNT * SLOT_STRIDE);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-1:0] REG_POOL_BASE = '0;

  typedef enum logic [1:0] {
    OP_ACQUIRE,
    OP_OVERSIZE,
    OP_RELEASE,
    OP_REJECT
  } op_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic               grant_ok;
    logic [GRANT_W-1:0] granted_slot;
    logic               release_ok;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   miss_total;
    logic [CNT_W-1:0]   too_large_total;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] slot_idx;
  } job_t;

endpackage

### rtl/rrspa_front.sv
`timescale 1ns / 1ps

module rrspa_front import rrspa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  input  logic [ADDR_W-1:0] base_i,
  output logic              job_valid_o,
  output job_t              job_o,
  input  logic              job_pop_i
);

  logic [ADDR_W:0]   diff;
  logic              in_pool;
  job_t              job_new;
  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;

  always_comb begin
    diff    = {1'b0, in_data_i.release_address} - {1'b0, base_i};
    in_pool = !diff[ADDR_W] && (diff[ADDR_W-1:0] < POOL_SPAN);
    job_new.slot_idx = IDX_W'(diff[ADDR_W-1:0] >> STRIDE_SH);
    if (in_data_i.command) begin
      job_new.op = in_pool ? OP_RELEASE : OP_REJECT;
    end else if (in_data_i.request_size > SIZE_W'(SLOT_MAX_BYTES)) begin
      job_new.op = OP_OVERSIZE;
    end else begin
      job_new.op = OP_ACQUIRE;
    end
  end

  assign in_stall_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (count_q != '0);
  assign job_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (job_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !job_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && job_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

### rtl/rrspa_back.sv
`timescale 1ns / 1ps

module rrspa_back import rrspa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic [POOL_W-1:0] RESET_BUSY = ~({POOL_W{1'b1}} >> (POOL_W - SLOT_COUNT));

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  ptr_q;
  logic [WORD_W-1:0] word_q;
  logic [STEP_W-1:0] step_q;
  logic [POOL_W-1:0] busy_q;
  logic [CNT_W-1:0]  hit_q, miss_q, big_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              out_free;
  logic [SCAN_W-1:0] word_bits;
  logic [SCAN_W-1:0] lo_mask;
  logic [SCAN_W-1:0] mask;
  logic [SCAN_W-1:0] free_bits;
  logic              found;
  logic              last_step;
  logic [OFF_W-1:0]  hit_off;
  logic [IDX_W-1:0]  hit_idx;

  logic              scan_start;
  logic              res_load;
  logic              grant;
  logic              release_slot;
  logic              miss_inc;
  logic              big_inc;
  out_item_t         res;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign word_bits = busy_q[{word_q, OFF_W'(0)} +: SCAN_W];
  assign lo_mask   = {SCAN_W{1'b1}} << ptr_q[OFF_W-1:0];
  assign last_step = (step_q == STEP_W'(WORDS));

  always_comb begin
    if (step_q == '0) begin
      mask = lo_mask;
    end else if (last_step) begin
      mask = ~lo_mask;
    end else begin
      mask = '1;
    end
    free_bits = ~word_bits & mask;
    found     = |free_bits;
  end

  always_comb begin
    hit_off = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_off = OFF_W'(i);
      end
    end
  end

  assign hit_idx = {word_q, hit_off};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i && out_free && job_i.op == OP_ACQUIRE) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (found || last_step) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o             = 1'b0;
    scan_start            = 1'b0;
    res_load              = 1'b0;
    grant                 = 1'b0;
    release_slot          = 1'b0;
    miss_inc              = 1'b0;
    big_inc               = 1'b0;
    res                   = '0;
    res.hit_total         = hit_q;
    res.miss_total        = miss_q;
    res.too_large_total   = big_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i && out_free) begin
          job_pop_o = 1'b1;
          case (job_i.op)
            OP_ACQUIRE: scan_start = 1'b1;
            OP_OVERSIZE: begin
              res_load            = 1'b1;
              big_inc             = 1'b1;
              res.too_large_total = big_q + 1'b1;
            end
            OP_RELEASE: begin
              res_load       = 1'b1;
              release_slot   = 1'b1;
              res.release_ok = 1'b1;
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (found) begin
          res_load         = 1'b1;
          grant            = 1'b1;
          res.grant_ok     = 1'b1;
          res.granted_slot = GRANT_W'(hit_idx);
          res.hit_total    = hit_q + 1'b1;
        end else if (last_step) begin
          res_load       = 1'b1;
          miss_inc       = 1'b1;
          res.miss_total = miss_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      word_q      <= '0;
      step_q      <= '0;
      busy_q      <= RESET_BUSY;
      hit_q       <= '0;
      miss_q      <= '0;
      big_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (scan_start) begin
        word_q <= ptr_q[IDX_W-1:OFF_W];
        step_q <= '0;
      end else if (state_q == ST_SCAN) begin
        word_q <= (word_q == WORD_W'(WORDS - 1)) ? '0 : word_q + 1'b1;
        step_q <= step_q + 1'b1;
      end
      if (grant) begin
        busy_q[hit_idx] <= 1'b1;
        ptr_q <= (hit_idx == IDX_W'(SLOT_COUNT - 1)) ? '0 : hit_idx + 1'b1;
        hit_q <= hit_q + 1'b1;
      end
      if (release_slot) begin
        busy_q[job_i.slot_idx] <= 1'b0;
      end
      if (miss_inc) begin
        miss_q <= miss_q + 1'b1;
      end
      if (big_inc) begin
        big_q <= big_q + 1'b1;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/round_robin_slot_pool_allocator_unit.sv
`timescale 1ns / 1ps

// Slot pool allocator with a round-robin free-slot search.
// Input channel in_*: one beat is an acquire (command 0, request_size) or a
// release (command 1, release_address). Output channel out_*: exactly one
// result beat per input beat, in order, carrying the grant or release status
// and the hit, miss and too-large counters after that beat.
// APB port: register 0 holds the pool base address; write it only while idle.
// The front classifies each beat (size check, range check, slot index) into a
// two-entry queue; the back owns the busy bitmap, pointer and counters.
// A release or rejected acquire passes through the queue entry and then the
// output register. An acquire scans the bitmap one 64-slot word per cycle
// from the search pointer until it finds a free slot or wraps back to it.
// The back takes one item at a time; the queue keeps accepting beats while
// a scan runs, until both of its entries are full.
// Reset clears every busy flag, the pointer, the counters and the base.
// A stalled result holds in the output register; the back waits for it to
// leave before finishing the next item, and the queue fills up behind it.

module round_robin_slot_pool_allocator_unit import rrspa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [ADDR_W-1:0] base_q;
  logic              job_valid;
  job_t              job;
  logic              job_pop;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr == REG_POOL_BASE);
  assign prdata  = reg_sel ? PDATA_W'(base_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      base_q <= ADDR_W'(pwdata);
    end
  end

  rrspa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .base_i      (base_q),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  rrspa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.grant_ok && out_data_o.release_ok))
    else $error("grant and release reported in one result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.grant_ok |-> out_data_o.granted_slot == '0)
    else $error("slot index reported without a grant");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid)
    else $error("queue popped while empty");
`endif

endmodule

### test/pool_tb_pkg.sv
`timescale 1ns / 1ps

package pool_tb_pkg;

  import rrspa_pkg::*;

  typedef enum logic {
    CMD_ACQUIRE,
    CMD_RELEASE
  } command_e;

endpackage

### test/pool_checker.sv
`timescale 1ns / 1ps

module pool_checker
  import rrspa_pkg::*;
  import pool_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_data_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 fault_count_o,
  output int                 pending_count_o,
  output int                 full_miss_count_o
);

  localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);

  logic [SLOT_COUNT-1:0] busy_map;
  logic [SLOT_IDX_W-1:0] scan_ptr;
  logic [CNT_W-1:0]      hits;
  logic [CNT_W-1:0]      misses;
  logic [CNT_W-1:0]      oversized;
  logic [ADDR_W-1:0]     base_addr;
  out_item_t             due_results[$];

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fault_count_o++;
    if (fault_count_o <= 50)
      $display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
  endtask

  function automatic out_item_t allocate_or_free(in_item_t beat);
    out_item_t   r;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] addr;
    int          idx;
    bit          found;
    r = '0;
    if (beat.command == CMD_ACQUIRE) begin
      if (beat.request_size > SLOT_MAX_BYTES) begin
        oversized++;
      end else begin
        found = 1'b0;
        for (int n = 0; n < SLOT_COUNT && !found; n++) begin
          idx = (int'(scan_ptr) + n) % SLOT_COUNT;
          if (!busy_map[idx]) begin
            found          = 1'b1;
            busy_map[idx]  = 1'b1;
            scan_ptr       = SLOT_IDX_W'((idx + 1) % SLOT_COUNT);
            hits++;
            r.grant_ok     = 1'b1;
            r.granted_slot = GRANT_W'(idx);
          end
        end
        if (!found) begin
          misses++;
          full_miss_count_o++;
        end
      end
    end else begin
      lo   = {32'b0, base_addr};
      hi   = lo + 64'(SLOT_COUNT) * 64'(SLOT_STRIDE);
      addr = {32'b0, beat.release_address};
      if (addr >= lo && addr < hi) begin
        busy_map[(addr - lo) / SLOT_STRIDE] = 1'b0;
        r.release_ok = 1'b1;
      end
    end
    r.hit_total       = hits;
    r.miss_total      = misses;
    r.too_large_total = oversized;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      busy_map          = '0;
      scan_ptr          = '0;
      hits              = '0;
      misses            = '0;
      oversized         = '0;
      base_addr         = '0;
      fault_count_o     = 0;
      full_miss_count_o = 0;
      due_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result beat with nothing expected", out_data_i.hit_total, '0);
        end else begin
          want = due_results.pop_front();
          if (out_data_i.grant_ok !== want.grant_ok)
            report_mismatch("grant_ok", out_data_i.grant_ok, want.grant_ok);
          if (out_data_i.granted_slot !== want.granted_slot)
            report_mismatch("granted_slot", out_data_i.granted_slot, want.granted_slot);
          if (out_data_i.release_ok !== want.release_ok)
            report_mismatch("release_ok", out_data_i.release_ok, want.release_ok);
          if (out_data_i.hit_total !== want.hit_total)
            report_mismatch("hit_total", out_data_i.hit_total, want.hit_total);
          if (out_data_i.miss_total !== want.miss_total)
            report_mismatch("miss_total", out_data_i.miss_total, want.miss_total);
          if (out_data_i.too_large_total !== want.too_large_total)
            report_mismatch("too_large_total", out_data_i.too_large_total,
                            want.too_large_total);
        end
      end
      if (in_valid_i && !in_stall_i)
        due_results.push_back(allocate_or_free(in_data_i));
      if (psel && penable && pready && paddr == REG_POOL_BASE) begin
        if (pwrite)
          base_addr = pwdata;
        else if (prdata !== base_addr)
          report_mismatch("pool base readback", prdata, base_addr);
      end
    end
    pending_count_o = due_results.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import rrspa_pkg::*;
  import pool_tb_pkg::*;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int          fault_count;
  int          pending_count;
  int          full_miss_count;
  int          beats_sent   = 0;
  int          base_changes = 0;
  bit          send_quiet   = 1'b0;
  bit          take_quiet   = 1'b0;
  logic [31:0] cur_base     = '0;

  round_robin_slot_pool_allocator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  pool_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .fault_count_o    (fault_count),
    .pending_count_o  (pending_count),
    .full_miss_count_o(full_miss_count)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_beat(in_item_t beat);
    int gap;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  task automatic request_slot(logic [SIZE_W-1:0] size);
    in_item_t beat;
    beat.command         = CMD_ACQUIRE;
    beat.request_size    = size;
    beat.release_address = $urandom();
    send_beat(beat);
  endtask

  task automatic return_addr(logic [ADDR_W-1:0] addr);
    in_item_t beat;
    beat.command         = CMD_RELEASE;
    beat.request_size    = SIZE_W'($urandom());
    beat.release_address = addr;
    send_beat(beat);
  endtask

  // drain every outstanding result, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_access(logic write, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= REG_POOL_BASE;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_pool_base(logic [ADDR_W-1:0] base);
    settle();
    apb_access(1'b1, base);
    apb_access(1'b0, '0);
    cur_base = base;
    base_changes++;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return SIZE_W'($urandom_range(SLOT_MAX_BYTES + 1, 65535));
      1:       return SIZE_W'($urandom());
      default: return SIZE_W'($urandom_range(0, SLOT_MAX_BYTES));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr(logic [ADDR_W-1:0] base);
    case ($urandom_range(0, 19))
      0:          return base - 1;
      1:          return base + POOL_SPAN;
      2:          return base + POOL_SPAN - 1;
      3, 4, 5:    return $urandom();
      default:    return base + ADDR_W'($urandom_range(0, SLOT_COUNT - 1) * SLOT_STRIDE
                                        + $urandom_range(0, SLOT_STRIDE - 1));
    endcase
  endfunction

  task automatic random_phase(logic [ADDR_W-1:0] base, int acquire_pct, int count);
    set_pool_base(base);
    repeat (count) begin
      if ($urandom_range(0, 99) < acquire_pct) request_slot(pick_size());
      else return_addr(pick_addr(cur_base));
    end
  endtask

  initial begin : result_taker
    int hold;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) take_quiet = !take_quiet;
      hold = take_quiet ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_pool_base(32'h0000_0000);
    request_slot(16'd0);
    request_slot(16'd256);
    request_slot(16'd257);
    request_slot(16'hFFFF);
    request_slot(16'd1);
    return_addr(32'h0000_0000);
    return_addr(32'h0000_01FF);
    return_addr(32'h0000_0000);
    return_addr(32'h0000_FFFF);
    return_addr(32'h0001_0000);
    return_addr(32'hFFFF_FFFF);
    request_slot(16'd100);

    set_pool_base(32'h0000_1000);
    return_addr(32'h0000_0FFF);
    return_addr(32'h0000_1000);
    return_addr(32'h0001_0FFF);
    return_addr(32'h0001_1000);

    // end of pool lies above the 32-bit range
    set_pool_base(32'hFFFF_FFFF);
    request_slot(16'd256);
    return_addr(32'hFFFF_FFFF);
    return_addr(32'h0000_FFFE);

    random_phase(32'h0000_0000, 95, 300);
    random_phase(32'hFFFF_0000, 20, 200);
    random_phase(32'hFFFF_FFFF, 50, 100);
    random_phase($urandom(), 90, 200);
    random_phase(32'h1234_5678, 50, 100);

    settle();
    $display("%0d request beats over %0d pool base settings with random gaps and stalls",
             beats_sent, base_changes);
    $display("%0d acquires found the pool full; %0d mismatches", full_miss_count, fault_count);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
